// ===== hdl/fbfb_pkg.sv =====
// Shared types, constants and opcodes for the framebuffer fill and blit engine.
package fbfb_pkg;

    localparam int FB_PIXELS_DEF = 65536;
    localparam int MAX_SIDE_DEF  = 1024;
    localparam logic [31:0] FULL_FILL_MARK = 32'h0000_00ff;

    typedef enum logic [2:0] {
        OP_SET_PIXEL = 3'd0,
        OP_GET_PIXEL = 3'd1,
        OP_FILL_RECT = 3'd2,
        OP_FILL_FULL = 3'd3,
        OP_SET_WIN   = 3'd4,
        OP_WIN_WRITE = 3'd5,
        OP_WIN_READ  = 3'd6,
        OP_UNUSED    = 3'd7
    } op_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_NO_WIN = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [11:0] x_first;
        logic signed [11:0] y_first;
        logic signed [11:0] x_last;
        logic signed [11:0] y_last;
        logic [10:0]        win_width;
        logic [10:0]        win_height;
        logic [31:0]        pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] pixel_out;
    } out_item_t;

    // Kind of work the back end performs
    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_WRITE = 2'd1,
        K_READ  = 2'd2,
        K_FILL  = 2'd3
    } kind_t;

    // Classified command: pixel span in screen coordinates plus row pitch
    typedef struct packed {
        kind_t       kind;
        logic [1:0]  status;
        logic        full;
        logic [10:0] x0;
        logic [10:0] x1;
        logic [10:0] y0;
        logic [10:0] y1;
        logic [10:0] pitch;
        logic [31:0] pixel;
    } cmd_t;

endpackage

// ===== hdl/fbfb_front.sv =====
// Front end: checks geometry, tracks the transfer window and classifies each item.
module fbfb_front #(
    parameter int FB_PIXELS = fbfb_pkg::FB_PIXELS_DEF,
    parameter int MAX_SIDE  = fbfb_pkg::MAX_SIDE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  fbfb_pkg::in_item_t in_item,
    output logic               cmd_valid,
    input  logic               cmd_stall,
    output fbfb_pkg::cmd_t     cmd
);
    import fbfb_pkg::*;

    logic [10:0] width_reg, height_reg;
    logic        geo_ok;
    logic [10:0] wl_reg, wt_reg, wr_reg, wb_reg, cc_reg, cr_reg;
    logic [10:0] wl_next, wt_next, wr_next, wb_next, cc_next, cr_next;
    logic        wo_reg, wo_next;
    logic [21:0] area;
    logic        x1_ok, y1_ok, x2_ok, y2_ok;
    logic [11:0] xe, ye;
    logic        take;
    logic        cmd_valid_reg;
    cmd_t        cmd_reg;
    cmd_t        cmd_c;

    assign area = width_reg * height_reg;
    assign geo_ok = (width_reg != 11'd0) && (height_reg != 11'd0)
                  && ({21'd0, width_reg} <= 32'(MAX_SIDE))
                  && ({21'd0, height_reg} <= 32'(MAX_SIDE))
                  && ({10'd0, area} <= 32'(FB_PIXELS));

    assign x1_ok = !in_item.x_first[11] && (in_item.x_first[10:0] < width_reg);
    assign y1_ok = !in_item.y_first[11] && (in_item.y_first[10:0] < height_reg);
    assign x2_ok = !in_item.x_last[11] && (in_item.x_last[10:0] < width_reg);
    assign y2_ok = !in_item.y_last[11] && (in_item.y_last[10:0] < height_reg);
    assign xe = {1'b0, in_item.x_first[10:0]} + {1'b0, in_item.win_width};
    assign ye = {1'b0, in_item.y_first[10:0]} + {1'b0, in_item.win_height};

    assign in_stall = cmd_valid && cmd_stall;
    assign take = in_valid && !in_stall;

    always_comb
    begin
        wl_next = wl_reg; wt_next = wt_reg; wr_next = wr_reg; wb_next = wb_reg;
        cc_next = cc_reg; cr_next = cr_reg; wo_next = wo_reg;
        cmd_c = '0;
        cmd_c.kind = K_NONE;
        cmd_c.status = ST_OK;
        cmd_c.pitch = width_reg;
        cmd_c.pixel = in_item.pixel_in;
        cmd_c.x0 = in_item.x_first[10:0];
        cmd_c.y0 = in_item.y_first[10:0];
        cmd_c.x1 = in_item.x_first[10:0];
        cmd_c.y1 = in_item.y_first[10:0];
        if (in_item.op <= OP_SET_WIN && !geo_ok)
        begin
            cmd_c.status = ST_RANGE;
        end
        else
        begin
            unique case (op_t'(in_item.op))
                OP_SET_PIXEL, OP_GET_PIXEL:
                begin
                    if (!x1_ok || !y1_ok)
                        cmd_c.status = ST_RANGE;
                    else
                        cmd_c.kind = (in_item.op == OP_SET_PIXEL) ? K_WRITE : K_READ;
                end
                OP_FILL_RECT:
                begin
                    if (!x1_ok || !x2_ok || !y1_ok || !y2_ok
                        || in_item.x_last < in_item.x_first
                        || in_item.y_last < in_item.y_first)
                        cmd_c.status = ST_RANGE;
                    else
                    begin
                        cmd_c.kind = K_FILL;
                        cmd_c.x1 = in_item.x_last[10:0];
                        cmd_c.y1 = in_item.y_last[10:0];
                    end
                end
                OP_FILL_FULL:
                begin
                    cmd_c.kind = K_FILL;
                    cmd_c.full = 1'b1;
                    cmd_c.x0 = '0;
                    cmd_c.y0 = '0;
                    cmd_c.x1 = width_reg - 11'd1;
                    cmd_c.y1 = height_reg - 11'd1;
                end
                OP_SET_WIN:
                begin
                    if (in_item.win_width == 11'd0 || in_item.win_height == 11'd0
                        || !x1_ok || !y1_ok || xe > {1'b0, width_reg}
                        || ye > {1'b0, height_reg})
                        cmd_c.status = ST_RANGE;
                    else
                    begin
                        wl_next = in_item.x_first[10:0];
                        wt_next = in_item.y_first[10:0];
                        wr_next = xe[10:0] - 11'd1;
                        wb_next = ye[10:0] - 11'd1;
                        cc_next = in_item.x_first[10:0];
                        cr_next = in_item.y_first[10:0];
                        wo_next = 1'b1;
                    end
                end
                OP_WIN_WRITE, OP_WIN_READ:
                begin
                    if (!wo_reg)
                        cmd_c.status = ST_NO_WIN;
                    else
                    begin
                        cmd_c.kind = (in_item.op == OP_WIN_WRITE) ? K_WRITE : K_READ;
                        cmd_c.x0 = cc_reg;
                        cmd_c.y0 = cr_reg;
                        if (cc_reg >= wr_reg)
                        begin
                            cc_next = wl_reg;
                            if (cr_reg >= wb_reg)
                                wo_next = 1'b0;
                            else
                                cr_next = cr_reg + 11'd1;
                        end
                        else
                            cc_next = cc_reg + 11'd1;
                    end
                end
                default: cmd_c.status = ST_RANGE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 11'd256; height_reg <= 11'd256;
            wl_reg <= '0; wt_reg <= '0; wr_reg <= '0; wb_reg <= '0;
            cc_reg <= '0; cr_reg <= '0; wo_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_WIDTH)
                    width_reg <= cfg_data;
                else
                    height_reg <= cfg_data;
                wo_reg <= 1'b0;
            end
            else if (take)
            begin
                wl_reg <= wl_next; wt_reg <= wt_next; wr_reg <= wr_next;
                wb_reg <= wb_next; cc_reg <= cc_next; cr_reg <= cr_next;
                wo_reg <= wo_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else if (!in_stall)
            cmd_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cmd_reg <= cmd_c;
    end

    assign cmd_valid = cmd_valid_reg;
    // cmd output port carries the registered command
    // (combinational classification stays internal)
    assign cmd = cmd_reg;
endmodule

// ===== hdl/fbfb_queue.sv =====
// Short command queue between the front and back ends.
module fbfb_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_stall,
    input  fbfb_pkg::cmd_t wr_cmd,
    output logic           rd_valid,
    input  logic           rd_stall,
    output fbfb_pkg::cmd_t rd_cmd
);
    import fbfb_pkg::*;

    localparam int AW = $clog2(DEPTH);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign wr_stall = (cnt_reg == (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign push = wr_valid && !wr_stall;
    assign pop  = rd_valid && !rd_stall;
    assign rd_cmd = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wr_cmd;
    end
endmodule

// ===== hdl/fbfb_back.sv =====
// Back end: walks fills pixel by pixel, performs pixel accesses and emits results.
module fbfb_back #(
    parameter int FB_PIXELS = fbfb_pkg::FB_PIXELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  fbfb_pkg::cmd_t      cmd,
    output logic                out_valid,
    input  logic                out_stall,
    output fbfb_pkg::out_item_t out_item
);
    import fbfb_pkg::*;

    localparam int AW = $clog2(FB_PIXELS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FILL = 4'b0010,
        S_READ = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] mem [FB_PIXELS];
    logic [10:0] x_reg, y_reg;
    logic [21:0] row_reg;
    logic [21:0] addr_full;
    cmd_t        c_reg;
    logic [1:0]  st_reg;
    logic [31:0] rdata_reg;
    logic        rd_sel_reg;
    logic        ov_reg;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0] wdata;
    logic        re;
    logic        take;
    logic        last;

    assign take = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign addr_full = row_reg + {11'd0, x_reg};
    assign last = (x_reg == c_reg.x1) && (y_reg == c_reg.y1);

    // address of a direct pixel access: x + y*pitch, one multiply
    logic [21:0] paddr;
    assign paddr = {11'd0, cmd.x0} + cmd.y0 * cmd.pitch;

    always_comb
    begin
        we = 1'b0; re = 1'b0;
        waddr = paddr[AW-1:0]; raddr = paddr[AW-1:0];
        wdata = cmd.pixel;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    unique case (cmd.kind)
                        K_WRITE: we = (paddr < 22'(FB_PIXELS));
                        K_READ:  begin re = 1'b1; state_next = S_READ; end
                        K_FILL:  state_next = S_FILL;
                        default: ;
                    endcase
                end
            end
            S_FILL:
            begin
                waddr = addr_full[AW-1:0];
                wdata = (last && c_reg.full) ? FULL_FILL_MARK : c_reg.pixel;
                we = (addr_full < 22'(FB_PIXELS));
                if (last)
                    state_next = S_OUT;
            end
            S_READ:  state_next = S_OUT;
            S_OUT:   if (!(ov_reg && out_stall)) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && take && cmd.kind != K_FILL && cmd.kind != K_READ)
                ov_reg <= 1'b1;
            else if (state_reg == S_OUT && !(ov_reg && out_stall))
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && take)
        begin
            c_reg <= cmd;
            x_reg <= cmd.x0;
            y_reg <= cmd.y0;
            row_reg <= cmd.y0 * cmd.pitch;
            st_reg <= cmd.status;
            rd_sel_reg <= (cmd.kind == K_READ) && (paddr < 22'(FB_PIXELS));
        end
        else if (state_reg == S_FILL && !last)
        begin
            if (x_reg == c_reg.x1)
            begin
                x_reg <= c_reg.x0;
                y_reg <= y_reg + 11'd1;
                row_reg <= row_reg + {11'd0, c_reg.pitch};
            end
            else
                x_reg <= x_reg + 11'd1;
        end
    end

    assign out_valid = ov_reg;
    assign out_item.status = st_reg;
    assign out_item.pixel_out = rd_sel_reg ? rdata_reg : 32'd0;
endmodule

// ===== hdl/framebuffer_fill_and_blit_top.sv =====
// Top level of the framebuffer fill and blit engine.
// Usage:
//   Input channel in_valid/in_stall carries one command item (in_item).
//   Output channel out_valid/out_stall returns exactly one result item per
//   command, in order: status and the pixel read (zero otherwise).
//   Configuration: cfg_we/cfg_index/cfg_data write screen_width (0) and
//   screen_height (1); any write closes the open window. Write only when idle.
// Timing:
//   The front end classifies each item into a registered command that enters
//   a four-entry queue. The back end handles a pixel write or failed command
//   in S_IDLE, a read in S_READ then S_OUT, and a fill in S_FILL then S_OUT,
//   one pixel per cycle through the single write port of the frame store.
//   Throughput is one item per cycle at best; a write's result passes the
//   front-end command register, the queue and the back-end output register.
// Reset:
//   Clears the window and handshakes, sets the size to 256 x 256; frame store
//   contents are undefined until written.
// Stalls:
//   out_stall holds the result; the queue then fills and in_stall rises.
module framebuffer_fill_and_blit_top #(
    parameter int FB_PIXELS = fbfb_pkg::FB_PIXELS_DEF,
    parameter int MAX_SIDE  = fbfb_pkg::MAX_SIDE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [10:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  fbfb_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output fbfb_pkg::out_item_t out_item
);
    import fbfb_pkg::*;

    logic f_valid, f_stall, q_valid, q_stall;
    cmd_t f_cmd, q_cmd;

    fbfb_front #(.FB_PIXELS(FB_PIXELS), .MAX_SIDE(MAX_SIDE)) u_front (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .in_valid, .in_stall, .in_item,
        .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd(f_cmd)
    );

    fbfb_queue #(.DEPTH(4)) u_queue (
        .clk, .rst_n,
        .wr_valid(f_valid), .wr_stall(f_stall), .wr_cmd(f_cmd),
        .rd_valid(q_valid), .rd_stall(q_stall), .rd_cmd(q_cmd)
    );

    fbfb_back #(.FB_PIXELS(FB_PIXELS)) u_back (
        .clk, .rst_n,
        .cmd_valid(q_valid), .cmd_stall(q_stall), .cmd(q_cmd),
        .out_valid, .out_stall, .out_item
    );

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result dropped under stall");
    a_status_pix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != ST_OK |-> out_item.pixel_out == 32'd0)
        else $error("failed command returned pixel data");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.status != 2'd3)
        else $error("illegal status");
endmodule
